// File: rtl/sms_pkg.sv
// Package for the stepper move sequencer: beat types, register indexes,
// request codes, datapath widths and the coil pattern lookup.
// No dependencies.
`timescale 1ns / 1ps

package sms_pkg;

    // Field widths
    localparam int unsigned DIST_W      = 24;
    localparam int unsigned DUR_W       = 16;
    localparam int unsigned COIL_W      = 4;
    localparam int unsigned SPM_W       = 8;
    localparam int unsigned STEPS_W     = 24;
    localparam int unsigned TICK_W      = 26;
    localparam int unsigned PROD_W      = DIST_W + SPM_W;
    localparam int unsigned DUR_SCALE_W = 27;

    // Divider widths: dividend is 2000*duration + steps - 1, divisor is 2*steps
    localparam int unsigned DIV_NUM_W   = 28;
    localparam int unsigned DIV_DEN_W   = 24;

    // Configuration port
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_MM  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_AT_END = 1'd1;

    localparam logic [SPM_W-1:0] STEPS_PER_MM_RST   = 8'd25;
    localparam logic             RELEASE_AT_END_RST = 1'b1;

    // Request codes
    localparam logic REQ_MOVE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Round-half-down bias for the 1/256 step product
    localparam logic [PROD_W-1:0] STEP_ROUND = 32'd127;
    localparam logic [10:0]       US_PER_MS2 = 11'd2000;

    typedef struct packed {
        logic                     req_type;
        logic signed [DIST_W-1:0] distance;
        logic [DUR_W-1:0]         duration_ms;
    } in_beat_t;

    typedef struct packed {
        logic [COIL_W-1:0] coils;
        logic              stepped;
        logic              busy_res;
        logic              rejected;
    } out_beat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Full-step two-phase pattern on coils a,b,c,d
    function automatic logic [COIL_W-1:0] coil_pattern(input logic [1:0] phase);
        logic [COIL_W-1:0] pat;
        case (phase)
            2'd0:    pat = 4'b1010;
            2'd1:    pat = 4'b0110;
            2'd2:    pat = 4'b0101;
            2'd3:    pat = 4'b1001;
            default: pat = 4'b0000;
        endcase
        return pat;
    endfunction

endpackage

// File: rtl/stepper_move_sequencer.sv
// Single-axis stepper move sequencer, top level.
// Depends on sms_pkg and sms_divider.
`timescale 1ns / 1ps

// Every input beat yields exactly one result beat. Tick beats, ignored
// commands (zero distance) and commands rejected while a move is running
// are answered from the idle state. A move's result is loaded after the
// step-count multiply, the division setup and the 28-bit restoring divider
// (28 quotient bits, one per cycle, then a done flag) that works out the
// step interval; a move whose step count rounds to zero skips the divider.
// s_ready stays low meanwhile, so no beat is taken before that result is
// loaded. The result register lets the next beat be accepted in the cycle
// its predecessor's result is taken. Configuration writes are taken at any
// time but should only be issued while no move command is being worked out.
module stepper_move_sequencer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  sms_pkg::in_beat_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output sms_pkg::out_beat_t                m_data,
    input  logic                              cfg_we,
    input  logic [sms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sms_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import sms_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_PREP = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [SPM_W-1:0]       spm_reg, spm_next;
    logic                   release_reg, release_next;
    logic [1:0]             phase_reg, phase_next;
    logic                   reverse_reg, reverse_next;
    logic [STEPS_W-1:0]     steps_left_reg, steps_left_next;
    logic [TICK_W-1:0]      countdown_reg, countdown_next;
    logic [TICK_W-1:0]      interval_reg, interval_next;
    logic                   moving_reg, moving_next;
    logic [COIL_W-1:0]      coil_reg, coil_next;
    logic [DIST_W-1:0]      mag_reg, mag_next;
    logic [DUR_W-1:0]       dur_reg, dur_next;
    logic [STEPS_W-1:0]     steps_reg, steps_next;
    logic [DUR_SCALE_W-1:0] dur_scaled_reg, dur_scaled_next;
    logic                   m_valid_reg, m_valid_next;
    out_beat_t              out_reg, out_next;

    logic                   s_accept;
    logic                   emit;
    logic                   stepped_c;
    logic                   rejected_c;
    logic [PROD_W-1:0]      product;
    logic [PROD_W-1:0]      rounded;
    logic                   div_start;
    logic [DIV_NUM_W-1:0]   div_num;
    logic [DIV_DEN_W-1:0]   div_den;
    logic [DIV_NUM_W-1:0]   div_quot;
    div_status_t            div_status;

    assign s_ready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_accept = s_valid && s_ready;

    // Step count: round-half-down of |distance| * steps_per_mm / 256
    assign product = PROD_W'(mag_reg) * PROD_W'(spm_reg);
    assign rounded = product + STEP_ROUND;

    // Interval dividend and divisor
    assign div_num = DIV_NUM_W'(dur_scaled_reg) + DIV_NUM_W'(steps_reg) - DIV_NUM_W'(1);
    assign div_den = {steps_reg[DIV_DEN_W-2:0], 1'b0};

    sms_divider #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (div_start),
        .numerator   (div_num),
        .denominator (div_den),
        .quotient    (div_quot),
        .status      (div_status)
    );

    always_comb begin
        state_next      = state_reg;
        spm_next        = spm_reg;
        release_next    = release_reg;
        phase_next      = phase_reg;
        reverse_next    = reverse_reg;
        steps_left_next = steps_left_reg;
        countdown_next  = countdown_reg;
        interval_next   = interval_reg;
        moving_next     = moving_reg;
        coil_next       = coil_reg;
        mag_next        = mag_reg;
        dur_next        = dur_reg;
        steps_next      = steps_reg;
        dur_scaled_next = dur_scaled_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_next        = out_reg;
        emit            = 1'b0;
        stepped_c       = 1'b0;
        rejected_c      = 1'b0;
        div_start       = 1'b0;

        // Configuration writes
        if (cfg_we) begin
            if (cfg_index == REG_STEPS_PER_MM) begin
                spm_next = cfg_wdata;
            end else if (cfg_index == REG_RELEASE_AT_END) begin
                release_next = cfg_wdata[0];
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_data.req_type == REQ_TICK) begin
                        emit = 1'b1;
                        if (moving_reg) begin
                            if (countdown_reg > TICK_W'(1)) begin
                                countdown_next = countdown_reg - 1'b1;
                            end else if (steps_left_reg != '0) begin
                                // Take the next step
                                steps_left_next = steps_left_reg - 1'b1;
                                countdown_next  = interval_reg;
                                coil_next       = coil_pattern(phase_reg);
                                phase_next      = reverse_reg ? phase_reg - 1'b1
                                                              : phase_reg + 1'b1;
                                stepped_c       = 1'b1;
                            end else begin
                                // Last interval over: end the move
                                moving_next    = 1'b0;
                                countdown_next = '0;
                                if (release_reg) begin
                                    coil_next = '0;
                                end
                            end
                        end
                    end else if (moving_reg) begin
                        emit       = 1'b1;
                        rejected_c = 1'b1;
                    end else if (s_data.distance == '0) begin
                        emit = 1'b1;
                    end else begin
                        // Take over direction and magnitude, start the sums
                        reverse_next = s_data.distance[DIST_W-1];
                        mag_next     = s_data.distance[DIST_W-1]
                                     ? DIST_W'(-s_data.distance)
                                     : DIST_W'(s_data.distance);
                        dur_next     = s_data.duration_ms;
                        state_next   = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                steps_next      = rounded[PROD_W-1:PROD_W-STEPS_W];
                dur_scaled_next = DUR_SCALE_W'(dur_reg) * DUR_SCALE_W'(US_PER_MS2);
                state_next      = ST_PREP;
            end
            ST_PREP: begin
                if (steps_reg == '0) begin
                    // Too short to step: direction kept, nothing moves
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    // Start the move with its first step
                    interval_next   = div_quot[TICK_W-1:0];
                    countdown_next  = div_quot[TICK_W-1:0];
                    steps_left_next = steps_reg - 1'b1;
                    moving_next     = 1'b1;
                    coil_next       = coil_pattern(phase_reg);
                    phase_next      = reverse_reg ? phase_reg - 1'b1 : phase_reg + 1'b1;
                    stepped_c       = 1'b1;
                    emit            = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Load the result register
        if (emit) begin
            m_valid_next      = 1'b1;
            out_next.coils    = coil_next;
            out_next.stepped  = stepped_c;
            out_next.busy_res = moving_next;
            out_next.rejected = rejected_c;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg        <= mag_next;
        dur_reg        <= dur_next;
        steps_reg      <= steps_next;
        dur_scaled_reg <= dur_scaled_next;
        out_reg        <= out_next;
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            spm_reg        <= STEPS_PER_MM_RST;
            release_reg    <= RELEASE_AT_END_RST;
            phase_reg      <= '0;
            reverse_reg    <= 1'b0;
            steps_left_reg <= '0;
            countdown_reg  <= '0;
            interval_reg   <= '0;
            moving_reg     <= 1'b0;
            coil_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            spm_reg        <= spm_next;
            release_reg    <= release_next;
            phase_reg      <= phase_next;
            reverse_reg    <= reverse_next;
            steps_left_reg <= steps_left_next;
            countdown_reg  <= countdown_next;
            interval_reg   <= interval_next;
            moving_reg     <= moving_next;
            coil_reg       <= coil_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// File: rtl/sms_divider.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on sms_pkg for widths and the status struct.
`timescale 1ns / 1ps

module sms_divider #(
    parameter int unsigned NUM_W = sms_pkg::DIV_NUM_W,
    parameter int unsigned DEN_W = sms_pkg::DIV_DEN_W
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [NUM_W-1:0]      numerator,
    input  logic [DEN_W-1:0]      denominator,
    output logic [NUM_W-1:0]      quotient,
    output sms_pkg::div_status_t  status
);
    import sms_pkg::*;

    localparam int unsigned CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             fits;

    // Trial subtract of the shifted remainder
    assign shifted = {rem_reg, num_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg) begin
            // Shift in one quotient bit
            num_next = {num_reg[NUM_W-2:0], fits};
            rem_next = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            num_next  = numerator;
            rem_next  = '0;
            den_next  = denominator;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient    = num_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
